// ----- hdl/bcfa_pkg.sv -----
// shared constants and types for the contiguous frame allocator
package bcfa_pkg;

  localparam int NUM_FRAMES_DEF = 1024;
  localparam int MAP_WORDS_DEF  = 32;

  localparam int WORD_BITS  = 32;
  localparam int WORD_SHIFT = 5;
  localparam int STEP_BITS  = 8;
  localparam int STEP_SHIFT = 3;
  localparam int STEP_W     = WORD_SHIFT - STEP_SHIFT;

  // widest map address the parameter range allows
  localparam int MAP_ADDR_MAX_W = 11;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  typedef struct packed {
    logic [MAP_ADDR_MAX_W-1:0] rd_addr;
    logic                      wr_en;
    logic [MAP_ADDR_MAX_W-1:0] wr_addr;
    logic [WORD_BITS-1:0]      wr_data;
    logic                      clear;
  } map_ctl_t;

endpackage

// ----- hdl/bitmap_contiguous_frame_allocator_core.sv -----
// first-fit contiguous frame allocator: bitmap scan, mark and count
// clear requests and requests rejected at setup finish in the setup state, with no map scan
// a scan reads each map word, then takes four byte steps through the run unit
// marking reads and then writes each touched word
// one request at a time: busy stays high until done; done is a one-cycle strobe
// synchronous reset empties the map at once through per-word valid bits, no sweep
module bitmap_contiguous_frame_allocator_core #(
  parameter int NUM_FRAMES = bcfa_pkg::NUM_FRAMES_DEF,
  parameter int MAP_WORDS  = bcfa_pkg::MAP_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [9:0]  start_frame,
  input  logic [10:0] count,
  output logic        done,
  output logic        ok,
  output logic [9:0]  first_frame,
  output logic [10:0] frames_in_use,
  output logic [10:0] frames_free
);

  localparam int MAP_BITS  = MAP_WORDS * bcfa_pkg::WORD_BITS;
  localparam int TOTAL     = (NUM_FRAMES < MAP_BITS) ? NUM_FRAMES : MAP_BITS;
  localparam int LAST_WORD = (TOTAL - 1) / bcfa_pkg::WORD_BITS;
  localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CW        = $clog2(TOTAL + 1);
  localparam int FW0       = (CW > 11) ? CW : 11;
  localparam int FW        = (FW0 > WW + bcfa_pkg::WORD_SHIFT) ? FW0
                                                               : WW + bcfa_pkg::WORD_SHIFT;

  localparam logic [WW-1:0] LAST_W  = WW'(LAST_WORD);
  localparam logic [FW-1:0] TOTAL_F = FW'(TOTAL);
  localparam logic [bcfa_pkg::STEP_W-1:0] LAST_STEP = '1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_SREAD, ST_SCAN, ST_WREAD, ST_WMOD
  } state_t;

  state_t                      state;
  logic [1:0]                  req;
  logic [FW-1:0]               from;
  logic [FW-1:0]               n;
  logic                        want;
  logic [WW-1:0]               word;
  logic [bcfa_pkg::STEP_W-1:0] step;
  logic [FW-1:0]               run;
  logic [FW-1:0]               run_start;
  logic [CW-1:0]               used;

  bcfa_pkg::map_ctl_t             map_ctl;
  logic [bcfa_pkg::WORD_BITS-1:0] rd_word;
  logic [bcfa_pkg::WORD_BITS-1:0] mask;
  logic [FW-1:0]                  base_frame;
  logic [FW-1:0]                  run_next;
  logic                           hit;
  logic [FW-1:0]                  hit_start;
  logic [FW-1:0]                  end_frame;
  logic [WW-1:0]                  end_word;
  logic [FW-1:0]                  used_w;
  logic [FW-1:0]                  used_sum;
  logic [FW-1:0]                  free_w;
  logic                           is_alloc;

  bcfa_frame_map #(
    .MAP_WORDS (MAP_WORDS),
    .AW        (WW)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .ctl     (map_ctl),
    .rd_word (rd_word)
  );

  assign base_frame = FW'({word, step, bcfa_pkg::STEP_SHIFT'(0)});

  bcfa_run_step #(
    .FW    (FW),
    .TOTAL (TOTAL)
  ) u_step (
    .word_bits  (rd_word),
    .step       (step),
    .base_frame (base_frame),
    .want       (want),
    .from       (from),
    .n          (n),
    .run_in     (run),
    .run_out    (run_next),
    .hit        (hit),
    .hit_start  (hit_start)
  );

  assign is_alloc  = (req == bcfa_pkg::REQ_ALLOC);
  assign end_frame = run_start + n - 1'b1;
  assign end_word  = end_frame[WW+bcfa_pkg::WORD_SHIFT-1:bcfa_pkg::WORD_SHIFT];
  assign used_w    = FW'(used);
  assign used_sum  = is_alloc ? used_w + n : used_w - n;
  assign free_w    = TOTAL_F - used_w;

  // bits of the current word that fall inside the run being changed
  always_comb begin
    logic [FW-1:0] f;
    for (int p = 0; p < bcfa_pkg::WORD_BITS; p++) begin
      f       = FW'({word, ~bcfa_pkg::WORD_SHIFT'(p)});
      mask[p] = (f >= run_start) && (f <= end_frame);
    end
  end

  always_comb begin
    map_ctl         = '0;
    map_ctl.rd_addr = bcfa_pkg::MAP_ADDR_MAX_W'(word);
    map_ctl.wr_addr = bcfa_pkg::MAP_ADDR_MAX_W'(word);
    map_ctl.wr_data = is_alloc ? (rd_word | mask) : (rd_word & ~mask);
    map_ctl.wr_en   = (state == ST_WMOD);
    map_ctl.clear   = (state == ST_SETUP) && (req == bcfa_pkg::REQ_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      used        <= '0;
      done        <= 1'b0;
      ok          <= 1'b0;
      first_frame <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            req   <= req_type;
            // an allocation always scans from frame zero
            from  <= (req_type == bcfa_pkg::REQ_ALLOC) ? '0 : FW'(start_frame);
            n     <= FW'(count);
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          run  <= '0;
          step <= '0;
          want <= ~is_alloc;
          if (req == bcfa_pkg::REQ_CLEAR) begin
            used        <= '0;
            done        <= 1'b1;
            ok          <= 1'b1;
            first_frame <= '0;
            state       <= ST_IDLE;
          end else if ((req == bcfa_pkg::REQ_ALLOC || req == bcfa_pkg::REQ_FREE) &&
                       n != '0 && (is_alloc || from < TOTAL_F)) begin
            word  <= is_alloc ? '0
                              : from[WW+bcfa_pkg::WORD_SHIFT-1:bcfa_pkg::WORD_SHIFT];
            state <= ST_SREAD;
          end else begin
            done        <= 1'b1;
            ok          <= 1'b0;
            first_frame <= '0;
            state       <= ST_IDLE;
          end
        end
        ST_SREAD: begin
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          priority if (hit) begin
            run_start <= hit_start;
            word      <= hit_start[WW+bcfa_pkg::WORD_SHIFT-1:bcfa_pkg::WORD_SHIFT];
            state     <= ST_WREAD;
          end else if (step == LAST_STEP) begin
            run  <= run_next;
            step <= '0;
            if (word == LAST_W) begin
              done        <= 1'b1;
              ok          <= 1'b0;
              first_frame <= '0;
              state       <= ST_IDLE;
            end else begin
              word  <= word + 1'b1;
              state <= ST_SREAD;
            end
          end else begin
            run  <= run_next;
            step <= step + 1'b1;
          end
        end
        ST_WREAD: begin
          state <= ST_WMOD;
        end
        ST_WMOD: begin
          if (word == end_word) begin
            used        <= used_sum[CW-1:0];
            done        <= 1'b1;
            ok          <= 1'b1;
            first_frame <= run_start[9:0];
            state       <= ST_IDLE;
          end else begin
            word  <= word + 1'b1;
            state <= ST_WREAD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state != ST_IDLE);
  assign frames_in_use = used_w[10:0];
  assign frames_free   = free_w[10:0];

  // a transaction taken while idle always leaves idle on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // a result only appears after work was under way
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != ST_IDLE)
    else $error("result strobe without a request in flight");

  // a failed request reports frame zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && !ok |-> first_frame == '0)
    else $error("failed request reported a nonzero frame");

  // whenever a result is reported, used and free frames account for the whole map
  a_counts: assert property (@(posedge clk) disable iff (rst)
    done |-> 11'(frames_in_use + frames_free) == 11'(TOTAL))
    else $error("frame counts do not add up");

  // marking never starts a word past the end of the run
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_WMOD |-> word <= end_word)
    else $error("map write beyond the run");

endmodule

// ----- hdl/bcfa_frame_map.sv -----
// frame bitmap storage with per-word valid bits and registered read
module bcfa_frame_map #(
  parameter int MAP_WORDS = bcfa_pkg::MAP_WORDS_DEF,
  parameter int AW        = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bcfa_pkg::map_ctl_t             ctl,
  output logic [bcfa_pkg::WORD_BITS-1:0] rd_word
);

  logic [bcfa_pkg::WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0]           word_valid;
  logic [bcfa_pkg::WORD_BITS-1:0] rd_data;
  logic                           rd_valid;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr[AW-1:0]] <= ctl.wr_data;
    end
    rd_data <= mem[ctl.rd_addr[AW-1:0]];
  end

  // a word never written since reset or clear reads as all free
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (ctl.clear) begin
        word_valid <= '0;
      end else if (ctl.wr_en) begin
        word_valid[ctl.wr_addr[AW-1:0]] <= 1'b1;
      end
      rd_valid <= word_valid[ctl.rd_addr[AW-1:0]];
    end
  end

  assign rd_word = rd_valid ? rd_data : '0;

endmodule

// ----- hdl/bcfa_run_step.sv -----
// one scan step: tracks the run length over one byte of a map word
module bcfa_run_step #(
  parameter int FW    = 11,
  parameter int TOTAL = bcfa_pkg::NUM_FRAMES_DEF
) (
  input  logic [bcfa_pkg::WORD_BITS-1:0] word_bits,
  input  logic [bcfa_pkg::STEP_W-1:0]    step,
  input  logic [FW-1:0]                  base_frame,
  input  logic                           want,
  input  logic [FW-1:0]                  from,
  input  logic [FW-1:0]                  n,
  input  logic [FW-1:0]                  run_in,
  output logic [FW-1:0]                  run_out,
  output logic                           hit,
  output logic [FW-1:0]                  hit_start
);

  localparam logic [FW-1:0] TOTAL_F = FW'(TOTAL);

  always_comb begin
    logic [FW-1:0]                   run;
    logic [FW-1:0]                   f;
    logic [bcfa_pkg::WORD_SHIFT-1:0] pos;
    logic                            m;
    run       = run_in;
    hit       = 1'b0;
    hit_start = '0;
    for (int j = 0; j < bcfa_pkg::STEP_BITS; j++) begin
      f   = base_frame + FW'(j);
      pos = {step, bcfa_pkg::STEP_SHIFT'(j)};
      // frame at position pos sits in bit 31 - pos of the word
      m   = (word_bits[~pos] == want) && (f >= from) && (f < TOTAL_F);
      run = m ? run + 1'b1 : '0;
      if (m && (run == n) && !hit) begin
        hit       = 1'b1;
        hit_start = f + 1'b1 - n;
      end
    end
    run_out = run;
  end

endmodule

// ----- test/tb_bitmap_contiguous_frame_allocator_core.sv -----
// testbench for the first-fit contiguous frame allocator core
`timescale 1ns / 1ps

module tb_bitmap_contiguous_frame_allocator_core;

  localparam int TOTAL_FRAMES = 1024;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_REQUESTS = 400;

  typedef struct packed {
    logic        ok;
    logic [9:0]  first;
    logic [10:0] in_use;
    logic [10:0] avail;
  } alloc_result_t;

  class alloc_scoreboard;
    bit            frame_busy[TOTAL_FRAMES];
    int            used_frames;
    alloc_result_t pending_results[$];
    int            mismatches;
    int            n_alloc_ok, n_free_ok, n_clear, n_rejected;

    // lowest start of n consecutive frames equal to want, scanning from `from`
    function int find_run(int from, int n, bit want);
      int run = 0;
      for (int fr = from; fr < TOTAL_FRAMES; fr++) begin
        if (frame_busy[fr] == want) begin
          run++;
          if (run == n) return fr + 1 - n;
        end else begin
          run = 0;
        end
      end
      return -1;
    endfunction

    function void note_request(logic [1:0] req, logic [9:0] from, logic [10:0] n);
      alloc_result_t exp_res;
      int s;
      exp_res = '0;
      s = -1;
      if (req == bcfa_pkg::REQ_CLEAR) begin
        foreach (frame_busy[i]) frame_busy[i] = 1'b0;
        used_frames = 0;
        exp_res.ok = 1'b1;
        n_clear++;
      end else if ((req == bcfa_pkg::REQ_ALLOC || req == bcfa_pkg::REQ_FREE) && n != 0) begin
        if (req == bcfa_pkg::REQ_ALLOC) s = find_run(0, int'(n), 1'b0);
        else s = find_run(int'(from), int'(n), 1'b1);
        if (s >= 0) begin
          for (int k = 0; k < int'(n); k++)
            frame_busy[s + k] = (req == bcfa_pkg::REQ_ALLOC);
          if (req == bcfa_pkg::REQ_ALLOC) begin
            used_frames += int'(n);
            n_alloc_ok++;
          end else begin
            used_frames -= int'(n);
            n_free_ok++;
          end
          exp_res.ok = 1'b1;
          exp_res.first = s[9:0];
        end
      end
      if (!exp_res.ok) n_rejected++;
      exp_res.in_use = used_frames[10:0];
      exp_res.avail = 11'(TOTAL_FRAMES - used_frames);
      pending_results.push_back(exp_res);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t exp_res;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"error: result with no request pending: ",
                    "ok=%0d first=%0d used=%0d free=%0d"},
                   got.ok, got.first, got.in_use, got.avail);
        return;
      end
      exp_res = pending_results.pop_front();
      if (got.ok != exp_res.ok || got.first != exp_res.first ||
          got.in_use != exp_res.in_use || got.avail != exp_res.avail) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"error: expected ok=%0d first=%0d used=%0d free=%0d, ",
                    "got ok=%0d first=%0d used=%0d free=%0d"},
                   exp_res.ok, exp_res.first, exp_res.in_use, exp_res.avail,
                   got.ok, got.first, got.in_use, got.avail);
      end
    endfunction

    // a frame currently in use, or any frame when none is in use or none turns up in 64 tries
    function int some_used_frame();
      int fr;
      fr = $urandom_range(0, TOTAL_FRAMES - 1);
      if (used_frames == 0) return fr;
      for (int tries = 0; tries < 64; tries++) begin
        fr = $urandom_range(0, TOTAL_FRAMES - 1);
        if (frame_busy[fr]) return fr;
      end
      return fr;
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  req_type;
  logic [9:0]  start_frame;
  logic [10:0] count;
  logic        done;
  logic        ok;
  logic [9:0]  first_frame;
  logic [10:0] frames_in_use;
  logic [10:0] frames_free;

  alloc_scoreboard sb = new();
  bit burst;

  bitmap_contiguous_frame_allocator_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .start_frame  (start_frame),
    .count        (count),
    .done         (done),
    .ok           (ok),
    .first_frame  (first_frame),
    .frames_in_use(frames_in_use),
    .frames_free  (frames_free)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // results are checked before new transactions are noted, keeping queue order
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result({ok, first_frame, frames_in_use, frames_free});
      if (start && !busy) sb.note_request(req_type, start_frame, count);
    end
  end

  // entered and left at a falling edge
  task automatic send_request(input logic [1:0] req, input logic [9:0] from,
                              input logic [10:0] n);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    req_type = req;
    start_frame = from;
    count = n;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain_pending();
    start = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [10:0] pick_count();
    if ($urandom_range(0, 19) == 0) return 11'($urandom_range(0, TOTAL_FRAMES));
    return 11'($urandom_range(1, 32));
  endfunction

  initial begin
    int sel;
    int fr;
    rst = 1'b1;
    start = 1'b0;
    req_type = bcfa_pkg::REQ_ALLOC;
    start_frame = '0;
    count = '0;
    burst = 1'b0;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: zero counts, full map, edges of the frame range
    send_request(bcfa_pkg::REQ_ALLOC, 10'd0, 11'd0);
    send_request(bcfa_pkg::REQ_FREE, 10'd0, 11'd0);
    send_request(bcfa_pkg::REQ_ALLOC, 10'd1023, 11'd1024);
    send_request(bcfa_pkg::REQ_ALLOC, 10'd0, 11'd1);
    send_request(bcfa_pkg::REQ_FREE, 10'd1023, 11'd1);
    send_request(bcfa_pkg::REQ_FREE, 10'd0, 11'd1024);
    send_request(bcfa_pkg::REQ_ALLOC, 10'd512, 11'd1);
    send_request(bcfa_pkg::REQ_FREE, 10'd100, 11'd10);
    // run below start_frame is cut off, the scan moves on past the hole
    send_request(bcfa_pkg::REQ_FREE, 10'd95, 11'd10);
    send_request(REQ_UNUSED, 10'h3FF, 11'h7FF);
    send_request(bcfa_pkg::REQ_CLEAR, 10'h2AA, 11'h555);
    send_request(bcfa_pkg::REQ_FREE, 10'd0, 11'd1);
    send_request(bcfa_pkg::REQ_ALLOC, 10'd0, 11'd1023);
    send_request(bcfa_pkg::REQ_ALLOC, 10'd0, 11'd2);
    send_request(bcfa_pkg::REQ_FREE, 10'd0, 11'd1023);
    send_request(bcfa_pkg::REQ_ALLOC, 10'd0, 11'd5);
    send_request(bcfa_pkg::REQ_FREE, 10'd3, 11'd3);
    send_request(bcfa_pkg::REQ_FREE, 10'd3, 11'd2);
    send_request(bcfa_pkg::REQ_FREE, 10'd1023, 11'd1);
    send_request(bcfa_pkg::REQ_ALLOC, 10'd0, 11'd1025);
    send_request(bcfa_pkg::REQ_CLEAR, 10'd0, 11'd0);
    drain_pending();

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 50 == 0) burst = ($urandom_range(0, 2) == 0);
      if (i % 100 == 60) drain_pending();
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        send_request(bcfa_pkg::REQ_ALLOC, 10'($urandom), pick_count());
      end else if (sel < 80) begin
        fr = sb.some_used_frame();
        fr = fr - $urandom_range(0, (fr < 4) ? fr : 4);
        send_request(bcfa_pkg::REQ_FREE, fr[9:0],
                     ($urandom_range(0, 4) == 0) ? pick_count()
                                                 : 11'($urandom_range(1, 8)));
      end else if (sel < 85) begin
        send_request(bcfa_pkg::REQ_CLEAR, 10'($urandom),
                     11'($urandom_range(0, TOTAL_FRAMES)));
      end else if (sel < 90) begin
        send_request(REQ_UNUSED, 10'($urandom), 11'($urandom_range(0, TOTAL_FRAMES)));
      end else begin
        send_request(2'($urandom_range(0, 1)), 10'($urandom),
                     ($urandom_range(0, 1) == 0) ? 11'd0
                                                 : 11'($urandom_range(0, TOTAL_FRAMES)));
      end
    end
    start = 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.mismatches += sb.pending_results.size();

    $display("run covered %0d allocations and %0d frees that succeeded, %0d clears",
             sb.n_alloc_ok, sb.n_free_ok, sb.n_clear);
    $display("and %0d rejected requests; %0d mismatches", sb.n_rejected, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb_bitmap_contiguous_frame_allocator_core passed");
    end else begin
      $display("tb_bitmap_contiguous_frame_allocator_core failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout waiting for the allocator");
    $display("tb_bitmap_contiguous_frame_allocator_core failed");
    $finish;
  end

endmodule
